// ----- rtl/tmorph_pkg.sv -----
// shared types and constants of the thresholded 3x3 morphology block
package tmorph_pkg;

   // item commands
   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LEVEL_THRESHOLD = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GROW_WHITE      = 2'd3;

   // register reset values
   localparam int         RESET_WIDTH     = 1024;
   localparam int         RESET_HEIGHT    = 1024;
   localparam logic [7:0] RESET_THRESHOLD = 8'd100;
   localparam logic       RESET_GROW      = 1'b1;

   // pixel levels forced by a neighbour hit
   localparam logic [7:0] PIXEL_WHITE = 8'd255;
   localparam logic [7:0] PIXEL_BLACK = 8'd0;

   // queue depths
   localparam int OPQ_DEPTH  = 4;
   localparam int RESQ_DEPTH = 4;

   // classified item handed from front to back
   typedef struct packed {
      logic       emit;
      logic [7:0] pixel;
   } op_type;

   // one result transaction
   typedef struct packed {
      logic [7:0] pixel_out;
      logic       row_end;
      logic       frame_end;
   } result_type;

endpackage

// ----- rtl/tmorph_ram.sv -----
// generic single write port ram with registered read
module tmorph_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/tmorph_fifo.sv -----
// small generic flip-flop queue with occupancy count
module tmorph_fifo #(
   parameter int WIDTH = 9,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      do_push   = push && (count_ff != CW'(DEPTH));
      do_pop    = pop && !empty;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/tmorph_front.sv -----
// front end: accepts items, tracks pipeline fill and drain, classifies each push
module tmorph_front import tmorph_pkg::*; #(
   parameter int MAX_WIDTH = 2048
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   output logic                             full,
   input  logic                             req_cmd,
   input  logic [7:0]                       req_pixel_in,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]   eff_width,
   output logic                             op_push,
   output op_type                           op_data,
   input  logic [$clog2(OPQ_DEPTH+1)-1:0]   op_count
);

   localparam int FW  = $clog2(MAX_WIDTH + 2);
   localparam int QCW = $clog2(OPQ_DEPTH + 1);

   logic [FW-1:0] fill_ff, fill_in;
   logic [FW-1:0] pending_ff, pending_in;
   logic          draining_ff, draining_in;
   logic [FW-1:0] depth;
   logic          primed;
   logic          accept;

   // classify the accepted transaction
   always_comb begin
      full          = (op_count == QCW'(OPQ_DEPTH));
      accept        = push && !full;
      depth         = FW'(eff_width) + FW'(1);
      primed        = (fill_ff >= depth);
      fill_in       = fill_ff;
      pending_in    = pending_ff;
      draining_in   = draining_ff;
      op_push       = 1'b0;
      op_data.emit  = primed;
      op_data.pixel = req_pixel_in;
      if (accept) begin
         case (req_cmd)
            CMD_PIXEL: begin
               // pixels are dropped while a drain is under way
               if (!draining_ff) begin
                  op_push = 1'b1;
                  if (!primed) begin
                     fill_in    = fill_ff + FW'(1);
                     pending_in = pending_ff + FW'(1);
                  end
               end
            end
            CMD_FLUSH: begin
               // flush pushes a dummy pixel while anything is pending
               if (pending_ff != '0) begin
                  op_push       = 1'b1;
                  op_data.pixel = PIXEL_BLACK;
                  draining_in   = 1'b1;
                  if (!primed) begin
                     fill_in = fill_ff + FW'(1);
                  end else begin
                     pending_in = pending_ff - FW'(1);
                     if (pending_ff == FW'(1)) begin
                        fill_in     = '0;
                        draining_in = 1'b0;
                     end
                  end
               end
            end
            default: begin
               op_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff     <= '0;
         pending_ff  <= '0;
         draining_ff <= 1'b0;
      end else begin
         fill_ff     <= fill_in;
         pending_ff  <= pending_in;
         draining_ff <= draining_in;
      end
   end

endmodule

// ----- rtl/tmorph_back.sv -----
// back end: line buffer, 3x3 window and neighbour threshold test
module tmorph_back import tmorph_pkg::*; #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [$clog2(MAX_WIDTH+1)-1:0]    eff_width,
   input  logic [$clog2(MAX_HEIGHT+1)-1:0]   eff_height,
   input  logic [7:0]                        level_threshold,
   input  logic                              grow_white,
   input  logic                              op_empty,
   input  op_type                            op_data,
   output logic                              op_pop,
   input  logic [$clog2(RESQ_DEPTH+1)-1:0]   res_count,
   output logic                              res_push,
   output result_type                        res_data
);

   localparam int COLW = $clog2(MAX_WIDTH);
   localparam int ROWW = $clog2(MAX_HEIGHT);

   // line buffer word: upper byte two rows up, lower byte one row up
   logic [COLW-1:0] in_col_ff, in_col_in;
   logic [15:0]     rd_word;
   logic [15:0]     line_word;
   logic [15:0]     wr_word;

   // stage 1: line buffer read returned
   logic            s1_valid_ff;
   op_type          s1_op_ff;
   logic [COLW-1:0] s1_addr_ff;
   logic            s1_hit_ff;
   logic [15:0]     s1_byp_ff;

   // stage 2: window holds the item, result goes out
   logic            s2_emit_ff;
   logic [7:0]      win_ff [3][3];
   logic [7:0]      win_in [3][3];

   logic [COLW-1:0] out_col_ff, out_col_in;
   logic [ROWW-1:0] out_row_ff, out_row_in;
   logic            interior, hit, rend;
   int              inflight;

   // issue only when the result queue has room for all emitting items in flight
   always_comb begin
      inflight = int'(res_count) + int'(s1_valid_ff && s1_op_ff.emit) + int'(s2_emit_ff);
      op_pop   = !op_empty && (inflight < RESQ_DEPTH);
      in_col_in = in_col_ff;
      if (op_pop) begin
         in_col_in = (32'(in_col_ff) + 32'd1 >= 32'(eff_width)) ? '0 : in_col_ff + COLW'(1);
      end
   end

   // bypass the write of the previous item when it hits the same column
   always_comb begin
      line_word = s1_hit_ff ? s1_byp_ff : rd_word;
      wr_word   = {line_word[7:0], s1_op_ff.pixel};
   end

   tmorph_ram #(
      .WIDTH (16),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_word),
      .rd_en   (op_pop),
      .rd_addr (in_col_ff),
      .rd_data (rd_word)
   );

   // window shift
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            win_in[r][c] = win_ff[r][c];
         end
      end
      if (s1_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = line_word[15:8];
         win_in[1][2] = line_word[7:0];
         win_in[2][2] = s1_op_ff.pixel;
      end
   end

   // neighbour test and raster position of the outgoing pixel
   always_comb begin
      interior = (out_col_ff != '0) && (32'(out_col_ff) + 32'd2 <= 32'(eff_width)) &&
                 (out_row_ff != '0) && (32'(out_row_ff) + 32'd2 <= 32'(eff_height));
      hit = 1'b0;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            if (!(r == 1 && c == 1)) begin
               if (grow_white ? (win_ff[r][c] > level_threshold)
                              : (win_ff[r][c] < level_threshold)) begin
                  hit = 1'b1;
               end
            end
         end
      end
      rend = (32'(out_col_ff) + 32'd1 >= 32'(eff_width));
      res_push           = s2_emit_ff;
      res_data.pixel_out = (interior && hit) ? (grow_white ? PIXEL_WHITE : PIXEL_BLACK)
                                             : win_ff[1][1];
      res_data.row_end   = rend;
      res_data.frame_end = rend && (32'(out_row_ff) + 32'd1 >= 32'(eff_height));
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (s2_emit_ff) begin
         if (rend) begin
            out_col_in = '0;
            out_row_in = (32'(out_row_ff) + 32'd1 >= 32'(eff_height)) ? '0
                                                                        : out_row_ff + ROWW'(1);
         end else begin
            out_col_in = out_col_ff + COLW'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff   <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         s1_valid_ff <= 1'b0;
         s2_emit_ff  <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         in_col_ff   <= in_col_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         s1_valid_ff <= op_pop;
         s2_emit_ff  <= s1_valid_ff && s1_op_ff.emit;
         win_ff      <= win_in;
      end
   end

   // stage 1 payload
   always_ff @(posedge clock) begin
      if (op_pop) begin
         s1_op_ff   <= op_data;
         s1_addr_ff <= in_col_ff;
         s1_hit_ff  <= s1_valid_ff && (s1_addr_ff == in_col_ff);
         s1_byp_ff  <= wr_word;
      end
   end

endmodule

// ----- rtl/threshold_morph_3x3.sv -----
// Streaming 3x3 thresholded morphology on 8-bit raster pixels.
// Throughput: one transaction per clock on each side while not full, not empty
// and the result queue has room; the line buffer is read per issued item and
// written from stage 1, with a bypass for back to back items in one column.
// Results pass stages 1 and 2; a pixel is released width+1 items after its own.
// Reset (synchronous): counters, window, queues and registers take reset values;
// the line buffer is not cleared and needs no clearing pass.
module threshold_morph_3x3 import tmorph_pkg::*; #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                   clock,
   input  logic                   reset,
   // input channel
   input  logic                   push,
   output logic                   full,
   input  logic                   req_cmd,
   input  logic [7:0]             req_pixel_in,
   // result channel
   output logic                   empty,
   input  logic                   pop,
   output logic [7:0]             rsp_pixel_out,
   output logic                   rsp_row_end,
   output logic                   rsp_frame_end,
   // configuration
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int EW = $clog2(MAX_WIDTH + 1);
   localparam int EH = $clog2(MAX_HEIGHT + 1);
   localparam int WIDTH_RST  = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
   localparam int HEIGHT_RST = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;
   localparam int OQW = $clog2(OPQ_DEPTH + 1);
   localparam int RQW = $clog2(RESQ_DEPTH + 1);

   logic [EW-1:0] width_ff, width_in;
   logic [EH-1:0] height_ff, height_in;
   logic [7:0]    threshold_ff, threshold_in;
   logic          grow_ff, grow_in;
   logic [11:0]   wr_width;
   logic [12:0]   wr_height;

   logic          op_push, op_pop, op_empty;
   op_type        op_wdata, op_rdata;
   logic [OQW-1:0] op_count;
   logic          res_push;
   result_type    res_wdata, res_rdata;
   logic [RQW-1:0] res_count;

   // register writes, sizes stored already clamped
   always_comb begin
      width_in     = width_ff;
      height_in    = height_ff;
      threshold_in = threshold_ff;
      grow_in      = grow_ff;
      wr_width     = csr_data[11:0];
      wr_height    = csr_data[12:0];
      if (csr_write) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               if (wr_width == '0) begin
                  width_in = EW'(1);
               end else if (32'(wr_width) > 32'(MAX_WIDTH)) begin
                  width_in = EW'(MAX_WIDTH);
               end else begin
                  width_in = EW'(wr_width);
               end
            end
            CSR_FRAME_HEIGHT: begin
               if (wr_height == '0) begin
                  height_in = EH'(1);
               end else if (32'(wr_height) > 32'(MAX_HEIGHT)) begin
                  height_in = EH'(MAX_HEIGHT);
               end else begin
                  height_in = EH'(wr_height);
               end
            end
            CSR_LEVEL_THRESHOLD: threshold_in = csr_data[7:0];
            CSR_GROW_WHITE:      grow_in      = csr_data[0];
            default:             grow_in      = grow_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= EW'(WIDTH_RST);
         height_ff    <= EH'(HEIGHT_RST);
         threshold_ff <= RESET_THRESHOLD;
         grow_ff      <= RESET_GROW;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         threshold_ff <= threshold_in;
         grow_ff      <= grow_in;
      end
   end

   // front end
   tmorph_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_cmd      (req_cmd),
      .req_pixel_in (req_pixel_in),
      .eff_width    (width_ff),
      .op_push      (op_push),
      .op_data      (op_wdata),
      .op_count     (op_count)
   );

   // queue between front and back
   tmorph_fifo #(
      .WIDTH ($bits(op_type)),
      .DEPTH (OPQ_DEPTH)
   ) u_op_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (op_wdata),
      .pop       (op_pop),
      .pop_data  (op_rdata),
      .empty     (op_empty),
      .count     (op_count)
   );

   // back end
   tmorph_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .eff_width       (width_ff),
      .eff_height      (height_ff),
      .level_threshold (threshold_ff),
      .grow_white      (grow_ff),
      .op_empty        (op_empty),
      .op_data         (op_rdata),
      .op_pop          (op_pop),
      .res_count       (res_count),
      .res_push        (res_push),
      .res_data        (res_wdata)
   );

   // result queue toward the consumer
   tmorph_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RESQ_DEPTH)
   ) u_res_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_wdata),
      .pop       (pop),
      .pop_data  (res_rdata),
      .empty     (empty),
      .count     (res_count)
   );

   assign rsp_pixel_out = res_rdata.pixel_out;
   assign rsp_row_end   = res_rdata.row_end;
   assign rsp_frame_end = res_rdata.frame_end;

endmodule

// ----- rtl/tmorph_checker.sv -----
// port-level checks of the morphology block and their binding
module tmorph_checker (
   input logic       clock,
   input logic       reset,
   input logic       full,
   input logic       empty,
   input logic       pop,
   input logic [7:0] rsp_pixel_out,
   input logic       rsp_row_end,
   input logic       rsp_frame_end
);

   // reset leaves both queues empty
   a_reset_clears : assert property (@(posedge clock)
      reset |=> empty && !full)
      else $error("queues not empty after reset");

   // a waiting result holds until it is taken
   a_result_holds : assert property (@(posedge clock) disable iff (reset)
      !empty && !pop |=> !empty && $stable(rsp_pixel_out) &&
                         $stable(rsp_row_end) && $stable(rsp_frame_end))
      else $error("waiting result changed before pop");

   // end of frame is always the end of a row
   a_frame_end_row : assert property (@(posedge clock) disable iff (reset)
      !empty && rsp_frame_end |-> rsp_row_end)
      else $error("frame end without row end");

endmodule

bind threshold_morph_3x3 tmorph_checker u_checker (.*);
